// File: rtl/core/i2cbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbs_pkg
// Shared types and codes for the I2C master byte sequencer.
// ----------------------------------------------------------------------------
package i2cbs_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned LEN_W   = 5;
    localparam int unsigned FAIL_W  = 5;

    // register index taken from paddr[2]
    localparam logic REG_MESSAGE_LENGTH = 1'b0;

    localparam logic [FAIL_W-1:0] NO_FAILURE = 5'd16;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_START = 2'd2,
        MODE_EVENT = 2'd3
    } mode_t;

    localparam logic [3:0] EV_START      = 4'd0;
    localparam logic [3:0] EV_RESTART    = 4'd1;
    localparam logic [3:0] EV_ADDRW_ACK  = 4'd2;
    localparam logic [3:0] EV_DATAW_ACK  = 4'd3;
    localparam logic [3:0] EV_DATAR_ACK  = 4'd4;
    localparam logic [3:0] EV_ADDRR_ACK  = 4'd5;
    localparam logic [3:0] EV_DATAR_NACK = 4'd6;
    localparam logic [3:0] EV_ARB_LOST   = 4'd7;

    localparam logic [7:0] RELEASED_SDA = 8'hFF;

    typedef struct packed {
        mode_t      mode;
        logic [3:0] index;
        logic [7:0] data;
        logic [3:0] ev;
        logic [7:0] rx;
    } item_t;

    typedef struct packed {
        logic              busy;
        logic              success;
        logic [FAIL_W-1:0] fail;
    } ctrl_state_t;

    typedef struct packed {
        logic [7:0]        transmit_byte;
        logic              transmit_valid;
        logic              send_ack;
        logic              request_start;
        logic              request_stop;
        logic              release_bus_step;
        logic              busy_res;
        logic              accepted;
        logic              transfer_ok;
        logic [FAIL_W-1:0] error_event;
        logic [7:0]        read_byte;
    } result_t;

endpackage

// File: rtl/core/i2cbs_buffer_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbs_buffer_ram
// Message buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module i2cbs_buffer_ram #(
    parameter int unsigned BUFFER_DEPTH = 16,
    parameter int unsigned AW           = 4
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [BUFFER_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/i2cbs_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbs_step
// Executes one item against the control state and the buffer read data.
// ----------------------------------------------------------------------------
module i2cbs_step #(
    parameter int unsigned BUFFER_DEPTH = 16,
    parameter int unsigned AW           = 4,
    parameter int unsigned PW           = 5
) (
    input  i2cbs_pkg::item_t                 item,
    input  i2cbs_pkg::ctrl_state_t           state,
    input  logic [PW-1:0]                    ptr,
    input  logic [i2cbs_pkg::LEN_W-1:0]      msg_len,
    input  logic [7:0]                       rdata,
    output i2cbs_pkg::ctrl_state_t           state_next,
    output logic [PW-1:0]                    ptr_next,
    output logic                             wr_en,
    output logic [AW-1:0]                    wr_addr,
    output logic [7:0]                       wr_data,
    output i2cbs_pkg::result_t               res
);

    logic [PW-1:0] idx_ext;
    logic          idx_ok;
    logic          is_start;
    logic [PW-1:0] p_sel;
    logic [PW-1:0] p_sel_inc;
    logic [PW-1:0] ptr_inc;
    logic          p_sel_ok;
    logic          ptr_ok;
    logic [PW-1:0] len_ext;
    logic [PW:0]   len_wide;

    assign idx_ext   = PW'(item.index);
    assign idx_ok    = idx_ext < PW'(BUFFER_DEPTH);
    assign is_start  = (item.ev == i2cbs_pkg::EV_START) || (item.ev == i2cbs_pkg::EV_RESTART);
    assign p_sel     = is_start ? '0 : ptr;
    // pointer saturates; all values past the length and depth behave alike
    assign p_sel_inc = (&p_sel) ? p_sel : p_sel + 1'b1;
    assign ptr_inc   = (&ptr) ? ptr : ptr + 1'b1;
    assign p_sel_ok  = p_sel < PW'(BUFFER_DEPTH);
    assign ptr_ok    = ptr < PW'(BUFFER_DEPTH);
    assign len_ext   = PW'(msg_len);
    assign len_wide  = (PW+1)'(msg_len);

    always_comb
    begin
        state_next = state;
        ptr_next   = ptr;
        wr_en      = 1'b0;
        wr_addr    = ptr[AW-1:0];
        wr_data    = item.rx;
        res        = '0;

        case (item.mode)
            i2cbs_pkg::MODE_LOAD:
            begin
                if (!state.busy && idx_ok)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_ext[AW-1:0];
                    wr_data = item.data;
                end
            end
            i2cbs_pkg::MODE_READ:
            begin
                if (idx_ok)
                begin
                    res.read_byte = rdata;
                end
            end
            i2cbs_pkg::MODE_START:
            begin
                if (!state.busy)
                begin
                    state_next.busy     = 1'b1;
                    state_next.success  = 1'b0;
                    state_next.fail     = i2cbs_pkg::NO_FAILURE;
                    res.request_start    = 1'b1;
                    res.release_bus_step = 1'b1;
                    res.accepted         = 1'b1;
                end
            end
            i2cbs_pkg::MODE_EVENT:
            begin
                if (state.busy)
                begin
                    case (item.ev)
                        i2cbs_pkg::EV_START, i2cbs_pkg::EV_RESTART,
                        i2cbs_pkg::EV_ADDRW_ACK, i2cbs_pkg::EV_DATAW_ACK:
                        begin
                            ptr_next = p_sel;
                            if (p_sel < len_ext)
                            begin
                                res.transmit_byte  = p_sel_ok ? rdata : i2cbs_pkg::RELEASED_SDA;
                                res.transmit_valid = 1'b1;
                                ptr_next           = p_sel_inc;
                            end
                            else
                            begin
                                state_next.success = 1'b1;
                                state_next.busy    = 1'b0;
                                res.request_stop   = 1'b1;
                            end
                            res.release_bus_step = 1'b1;
                        end
                        i2cbs_pkg::EV_DATAR_ACK:
                        begin
                            wr_en    = ptr_ok;
                            ptr_next = ptr_inc;
                            res.send_ack = ({1'b0, ptr_inc} + (PW+1)'(1)) < len_wide;
                            res.release_bus_step = 1'b1;
                        end
                        i2cbs_pkg::EV_ADDRR_ACK:
                        begin
                            res.send_ack = ({1'b0, ptr} + (PW+1)'(1)) < len_wide;
                            res.release_bus_step = 1'b1;
                        end
                        i2cbs_pkg::EV_DATAR_NACK:
                        begin
                            wr_en              = ptr_ok;
                            state_next.success = 1'b1;
                            state_next.busy    = 1'b0;
                            res.request_stop     = 1'b1;
                            res.release_bus_step = 1'b1;
                        end
                        i2cbs_pkg::EV_ARB_LOST:
                        begin
                            res.request_start    = 1'b1;
                            res.release_bus_step = 1'b1;
                        end
                        default:
                        begin
                            state_next.fail = {1'b0, item.ev};
                            state_next.busy = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase

        res.busy_res    = state_next.busy;
        res.transfer_ok = state_next.success;
        res.error_event = state_next.fail;
    end

endmodule

// File: rtl/core/i2c_master_byte_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer
// I2C master message sequencer: buffer load/read, start, bus event stepping.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  input    | in_valid / in_ready     | mode, buffer_index, buffer_byte,
//           |                         | bus_event, received_byte
//  output   | out_valid / out_ready   | transmit_byte ... read_byte
//  config   | APB psel/penable/pwrite | message_length at 0x0
//
//  One item per cycle sustained while the output is not stalled; the buffer
//  RAM read comes first, then the execute stage runs the item and
//  writes back; a write that hits the next item's read address is forwarded.
//  Reset clears the pointer, flags and pipeline valids; the buffer is not
//  cleared. A stalled output holds the execute stage, which holds the input.
// ----------------------------------------------------------------------------
module i2c_master_byte_sequencer #(
    parameter int unsigned BUFFER_DEPTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [i2cbs_pkg::ADDR_W-1:0]    paddr,
    input  logic [i2cbs_pkg::DATA_W-1:0]    pwdata,
    output logic [i2cbs_pkg::DATA_W-1:0]    prdata,
    output logic                            pready,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      mode,
    input  logic [3:0]                      buffer_index,
    input  logic [7:0]                      buffer_byte,
    input  logic [3:0]                      bus_event,
    input  logic [7:0]                      received_byte,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      transmit_byte,
    output logic                            transmit_valid,
    output logic                            send_ack,
    output logic                            request_start,
    output logic                            request_stop,
    output logic                            release_bus_step,
    output logic                            busy_res,
    output logic                            accepted,
    output logic                            transfer_ok,
    output logic [i2cbs_pkg::FAIL_W-1:0]    error_event,
    output logic [7:0]                      read_byte
);

    localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int unsigned PW = (AW + 1 > 5) ? AW + 1 : 5;

    logic [i2cbs_pkg::LEN_W-1:0] msg_len_reg;
    logic                        cfg_wr;

    i2cbs_pkg::ctrl_state_t      state_reg;
    i2cbs_pkg::ctrl_state_t      step_state;
    logic [PW-1:0]               ptr_reg;
    logic [PW-1:0]               step_ptr;
    logic [PW-1:0]               ptr_upd;

    logic                        s1_valid_reg;
    i2cbs_pkg::item_t            s1_item_reg;
    logic                        s1_fire;
    logic                        in_fire;
    i2cbs_pkg::item_t            in_item;

    logic                        out_valid_reg;
    i2cbs_pkg::result_t          res_reg;
    i2cbs_pkg::result_t          step_res;

    logic                        step_wr_en;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [7:0]                  wr_data;
    logic [PW-1:0]               rd_addr_full;
    logic [AW-1:0]               rd_addr;
    logic [7:0]                  ram_rdata;
    logic                        fwd_hit_reg;
    logic [7:0]                  fwd_data_reg;
    logic [7:0]                  rdata_eff;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == i2cbs_pkg::REG_MESSAGE_LENGTH);
    assign prdata = (paddr[2] == i2cbs_pkg::REG_MESSAGE_LENGTH)
                    ? i2cbs_pkg::DATA_W'(msg_len_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_len_reg <= '0;
        end
        else if (cfg_wr)
        begin
            msg_len_reg <= pwdata[i2cbs_pkg::LEN_W-1:0];
        end
    end

    // handshake
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    assign in_item.mode  = i2cbs_pkg::mode_t'(mode);
    assign in_item.index = buffer_index;
    assign in_item.data  = buffer_byte;
    assign in_item.ev    = bus_event;
    assign in_item.rx    = received_byte;

    // pointer as left by the item now executing
    assign ptr_upd = s1_fire ? step_ptr : ptr_reg;

    always_comb
    begin
        if (in_item.mode == i2cbs_pkg::MODE_READ)
        begin
            rd_addr_full = PW'(buffer_index);
        end
        else if ((bus_event == i2cbs_pkg::EV_START) || (bus_event == i2cbs_pkg::EV_RESTART))
        begin
            rd_addr_full = '0;
        end
        else
        begin
            rd_addr_full = ptr_upd;
        end
    end

    assign rd_addr = rd_addr_full[AW-1:0];
    assign wr_en   = step_wr_en && s1_fire;

    i2cbs_buffer_ram #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AW           (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (in_fire),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // write-to-read bypass for the entry written at the read edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    assign rdata_eff = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    i2cbs_step #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AW           (AW),
        .PW           (PW)
    ) u_step (
        .item       (s1_item_reg),
        .state      (state_reg),
        .ptr        (ptr_reg),
        .msg_len    (msg_len_reg),
        .rdata      (rdata_eff),
        .state_next (step_state),
        .ptr_next   (step_ptr),
        .wr_en      (step_wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .res        (step_res)
    );

    // execute stage and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            state_reg    <= '{busy: 1'b0, success: 1'b0, fail: i2cbs_pkg::NO_FAILURE};
            ptr_reg      <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                state_reg <= step_state;
                ptr_reg   <= step_ptr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= in_item;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid        = out_valid_reg;
    assign transmit_byte    = res_reg.transmit_byte;
    assign transmit_valid   = res_reg.transmit_valid;
    assign send_ack         = res_reg.send_ack;
    assign request_start    = res_reg.request_start;
    assign request_stop     = res_reg.request_stop;
    assign release_bus_step = res_reg.release_bus_step;
    assign busy_res         = res_reg.busy_res;
    assign accepted         = res_reg.accepted;
    assign transfer_ok      = res_reg.transfer_ok;
    assign error_event      = res_reg.error_event;
    assign read_byte        = res_reg.read_byte;

    // checks
    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken while execute stage is stalled");

    a_tx_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && transmit_valid) |-> (busy_res && !request_stop))
        else $error("byte sent outside a running transfer");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |->
            (busy_res && !transfer_ok && (error_event == i2cbs_pkg::NO_FAILURE)))
        else $error("accepted start did not reset transfer status");

    a_stop_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && request_stop) |-> (!busy_res && transfer_ok && !request_start))
        else $error("stop issued without completing the transfer");

endmodule

// File: test/i2c_master_byte_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer_tb
// Self-checking bench for the I2C master byte sequencer. A shadow copy of the
// buffer, pointer and flags predicts every result, and a scoreboard compares
// the results field by field in order. Stimulus is a short directed pass and
// then random write/read transfers with noise. The transfers run under
// several message lengths and several idle/stall mixes on both channels.
// ----------------------------------------------------------------------------
module i2c_master_byte_sequencer_tb;

    localparam int unsigned BUF_DEPTH  = 16;
    localparam int unsigned CURSOR_MAX = (1 << i2cbs_pkg::LEN_W) - 1;

    localparam logic [3:0] EV_ADDRW_NACK = 4'd8;
    localparam logic [3:0] EV_BUS_ERROR  = 4'd11;
    localparam logic [3:0] EV_OTHER_LAST = 4'd15;

    localparam logic [i2cbs_pkg::ADDR_W-1:0] ADDR_MESSAGE_LENGTH =
        {i2cbs_pkg::REG_MESSAGE_LENGTH, 2'b00};
    localparam logic [i2cbs_pkg::ADDR_W-1:0] ADDR_UNMAPPED =
        {~i2cbs_pkg::REG_MESSAGE_LENGTH, 2'b00};

    class sequencer_scoreboard;
        logic [7:0]                   shadow [BUF_DEPTH];
        int unsigned                  frame_len;
        int unsigned                  cursor;
        bit                           in_transfer;
        bit                           done_ok;
        logic [i2cbs_pkg::FAIL_W-1:0] last_fault;
        i2cbs_pkg::result_t           expected_results [$];
        int                           errors;
        int                           results_seen;

        function new();
            frame_len    = 0;
            cursor       = 0;
            in_transfer  = 1'b0;
            done_ok      = 1'b0;
            last_fault   = i2cbs_pkg::NO_FAILURE;
            errors       = 0;
            results_seen = 0;
            foreach (shadow[i])
                shadow[i] = 8'h00;
        endfunction

        task report(string msg);
            // keep the log short on a badly broken block; counting goes on
            if (errors < 100)
                $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function void write_reg(logic [i2cbs_pkg::ADDR_W-1:0] addr,
                                logic [i2cbs_pkg::DATA_W-1:0] data);
            if (addr[i2cbs_pkg::ADDR_W-1:2] == i2cbs_pkg::REG_MESSAGE_LENGTH)
                frame_len = data[i2cbs_pkg::LEN_W-1:0];
        endfunction

        // Returns 0 for loads during a transfer and events while idle, which the block simply ignores.
        function bit predict_item(i2cbs_pkg::item_t it);
            i2cbs_pkg::result_t r;
            bit                 effective;
            r = '0;
            effective = 1'b1;
            case (it.mode)
                i2cbs_pkg::MODE_LOAD:
                    if (in_transfer)
                        effective = 1'b0;
                    else
                        shadow[it.index] = it.data;
                i2cbs_pkg::MODE_READ:
                    r.read_byte = shadow[it.index];
                i2cbs_pkg::MODE_START:
                    if (!in_transfer)
                    begin
                        in_transfer        = 1'b1;
                        done_ok            = 1'b0;
                        last_fault         = i2cbs_pkg::NO_FAILURE;
                        r.request_start    = 1'b1;
                        r.release_bus_step = 1'b1;
                        r.accepted         = 1'b1;
                    end
                default:
                    if (!in_transfer)
                        effective = 1'b0;
                    else
                    begin
                        case (it.ev)
                            i2cbs_pkg::EV_START, i2cbs_pkg::EV_RESTART,
                            i2cbs_pkg::EV_ADDRW_ACK, i2cbs_pkg::EV_DATAW_ACK:
                            begin
                                if (it.ev == i2cbs_pkg::EV_START ||
                                    it.ev == i2cbs_pkg::EV_RESTART)
                                    cursor = 0;
                                if (cursor < frame_len)
                                begin
                                    // beyond the buffer the line is left released
                                    r.transmit_byte  = (cursor < BUF_DEPTH) ?
                                                       shadow[cursor] :
                                                       i2cbs_pkg::RELEASED_SDA;
                                    r.transmit_valid = 1'b1;
                                    if (cursor < CURSOR_MAX)
                                        cursor++;
                                end
                                else
                                begin
                                    done_ok        = 1'b1;
                                    in_transfer    = 1'b0;
                                    r.request_stop = 1'b1;
                                end
                                r.release_bus_step = 1'b1;
                            end
                            i2cbs_pkg::EV_DATAR_ACK, i2cbs_pkg::EV_ADDRR_ACK:
                            begin
                                if (it.ev == i2cbs_pkg::EV_DATAR_ACK)
                                begin
                                    if (cursor < BUF_DEPTH)
                                        shadow[cursor] = it.rx;
                                    if (cursor < CURSOR_MAX)
                                        cursor++;
                                end
                                r.send_ack         = (cursor + 1 < frame_len);
                                r.release_bus_step = 1'b1;
                            end
                            i2cbs_pkg::EV_DATAR_NACK:
                            begin
                                if (cursor < BUF_DEPTH)
                                    shadow[cursor] = it.rx;
                                done_ok            = 1'b1;
                                in_transfer        = 1'b0;
                                r.request_stop     = 1'b1;
                                r.release_bus_step = 1'b1;
                            end
                            i2cbs_pkg::EV_ARB_LOST:
                            begin
                                r.request_start    = 1'b1;
                                r.release_bus_step = 1'b1;
                            end
                            default:
                            begin
                                last_fault  = {1'b0, it.ev};
                                in_transfer = 1'b0;
                            end
                        endcase
                    end
            endcase
            r.busy_res    = in_transfer;
            r.transfer_ok = done_ok;
            r.error_event = last_fault;
            expected_results.push_back(r);
            return effective;
        endfunction

        task field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %0h, want %0h",
                                 results_seen, name, got, want));
        endtask

        task check_result(i2cbs_pkg::result_t got);
            i2cbs_pkg::result_t want;
            results_seen++;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing expected", results_seen));
                return;
            end
            want = expected_results.pop_front();
            field("transmit_byte", got.transmit_byte, want.transmit_byte);
            field("transmit_valid", got.transmit_valid, want.transmit_valid);
            field("send_ack", got.send_ack, want.send_ack);
            field("request_start", got.request_start, want.request_start);
            field("request_stop", got.request_stop, want.request_stop);
            field("release_bus_step", got.release_bus_step, want.release_bus_step);
            field("busy_res", got.busy_res, want.busy_res);
            field("accepted", got.accepted, want.accepted);
            field("transfer_ok", got.transfer_ok, want.transfer_ok);
            field("error_event", got.error_event, want.error_event);
            field("read_byte", got.read_byte, want.read_byte);
        endtask
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [i2cbs_pkg::ADDR_W-1:0] paddr;
    logic [i2cbs_pkg::DATA_W-1:0] pwdata;
    logic [i2cbs_pkg::DATA_W-1:0] prdata;
    logic                         pready;
    logic                         in_valid;
    logic                         in_ready;
    logic [1:0]                   mode;
    logic [3:0]                   buffer_index;
    logic [7:0]                   buffer_byte;
    logic [3:0]                   bus_event;
    logic [7:0]                   received_byte;
    logic                         out_valid;
    logic                         out_ready;
    logic [7:0]                   transmit_byte;
    logic                         transmit_valid;
    logic                         send_ack;
    logic                         request_start;
    logic                         request_stop;
    logic                         release_bus_step;
    logic                         busy_res;
    logic                         accepted;
    logic                         transfer_ok;
    logic [i2cbs_pkg::FAIL_W-1:0] error_event;
    logic [7:0]                   read_byte;

    sequencer_scoreboard sb;
    int                  sender_idle_pct;
    int                  recv_stall_pct;
    int                  counted_items;

    i2c_master_byte_sequencer #(
        .BUFFER_DEPTH(BUF_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .buffer_index(buffer_index),
        .buffer_byte(buffer_byte),
        .bus_event(bus_event),
        .received_byte(received_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .transmit_byte(transmit_byte),
        .transmit_valid(transmit_valid),
        .send_ack(send_ack),
        .request_start(request_start),
        .request_stop(request_stop),
        .release_bus_step(release_bus_step),
        .busy_res(busy_res),
        .accepted(accepted),
        .transfer_ok(transfer_ok),
        .error_event(error_event),
        .read_byte(read_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("i2c_master_byte_sequencer_tb NOT OK");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        i2cbs_pkg::result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = {transmit_byte, transmit_valid, send_ack, request_start, request_stop,
                   release_bus_step, busy_res, accepted, transfer_ok, error_event,
                   read_byte};
            sb.check_result(got);
        end
    end

    task automatic send_item(i2cbs_pkg::mode_t m, logic [3:0] idx, logic [7:0] d,
                             logic [3:0] ev);
        i2cbs_pkg::item_t it;
        it = '{mode: m, index: idx, data: d, ev: ev, rx: 8'($urandom)};
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid      <= 1'b1;
        mode          <= it.mode;
        buffer_index  <= it.index;
        buffer_byte   <= it.data;
        bus_event     <= it.ev;
        received_byte <= it.rx;
        do @(posedge clk); while (!in_ready);
        if (sb.predict_item(it))
            counted_items++;
    endtask

    task automatic send_event(logic [3:0] ev);
        send_item(i2cbs_pkg::MODE_EVENT, 4'($urandom), 8'($urandom), ev);
    endtask

    task automatic send_load(logic [3:0] idx, logic [7:0] d);
        send_item(i2cbs_pkg::MODE_LOAD, idx, d, 4'($urandom));
    endtask

    task automatic apb_write(logic [i2cbs_pkg::ADDR_W-1:0] addr,
                             logic [i2cbs_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(logic [i2cbs_pkg::ADDR_W-1:0] addr,
                            output logic [i2cbs_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Let every outstanding item drain before touching the register.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_length(int unsigned len, bit poke_unmapped);
        logic [i2cbs_pkg::DATA_W-1:0] wdata;
        logic [i2cbs_pkg::DATA_W-1:0] rb;
        settle();
        wdata = {27'($urandom), 5'(len)};
        apb_write(ADDR_MESSAGE_LENGTH, wdata);
        sb.write_reg(ADDR_MESSAGE_LENGTH, wdata);
        if (poke_unmapped)
        begin
            wdata = $urandom;
            apb_write(ADDR_UNMAPPED, wdata);
            sb.write_reg(ADDR_UNMAPPED, wdata);
        end
        apb_read(ADDR_MESSAGE_LENGTH, rb);
        if (rb[i2cbs_pkg::LEN_W-1:0] !== i2cbs_pkg::LEN_W'(sb.frame_len))
            sb.report($sformatf("message_length read %0d, want %0d",
                                rb[i2cbs_pkg::LEN_W-1:0], sb.frame_len));
    endtask

    task automatic send_noise();
        case ($urandom_range(4))
            0:
            begin
                send_event(i2cbs_pkg::EV_ARB_LOST);
                send_event(i2cbs_pkg::EV_RESTART);
            end
            1: send_item(i2cbs_pkg::MODE_START, 4'($urandom), 8'($urandom), 4'($urandom));
            2: send_load(4'($urandom), 8'($urandom));
            3: send_item(i2cbs_pkg::MODE_READ, 4'($urandom), 8'($urandom), 4'($urandom));
            default: send_event(4'($urandom));
        endcase
    endtask

    // One transfer: address byte, start, then acks until the block stops, closed by a nack or fault if needed.
    task automatic run_transfer();
        bit reading;
        bit overrun;
        int steps;
        reading = 1'($urandom);
        overrun = ($urandom_range(9) == 0);   // keep acking reads far past the end
        steps   = 0;
        send_load(4'd0, {7'($urandom), reading});
        repeat ($urandom_range(3))
            send_load(4'($urandom), 8'($urandom));
        if ($urandom_range(4) == 0)
            send_item(i2cbs_pkg::MODE_READ, 4'($urandom), 8'($urandom), 4'($urandom));
        send_item(i2cbs_pkg::MODE_START, 4'($urandom), 8'($urandom), 4'($urandom));
        send_event(($urandom_range(3) == 0) ? i2cbs_pkg::EV_RESTART : i2cbs_pkg::EV_START);
        send_event(reading ? i2cbs_pkg::EV_ADDRR_ACK : i2cbs_pkg::EV_ADDRW_ACK);
        while (sb.in_transfer && steps < 48)
        begin
            if ($urandom_range(99) < 5)
                send_noise();
            else if (!reading)
                send_event(i2cbs_pkg::EV_DATAW_ACK);
            else if (overrun ? (steps < 40) : (sb.cursor + 1 < sb.frame_len))
                send_event(i2cbs_pkg::EV_DATAR_ACK);
            else
                send_event(i2cbs_pkg::EV_DATAR_NACK);
            steps++;
        end
        if (sb.in_transfer)
            send_event(reading ? i2cbs_pkg::EV_DATAR_NACK : 4'($urandom_range(8, 15)));
        if ($urandom_range(4) == 0)
            send_event(4'($urandom));
    endtask

    initial
    begin : stimulus
        int phase_len [12];
        int goal;
        int guard;
        sb              = new();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        counted_items   = 0;
        phase_len       = '{0, 16, 31, 1, 2, 5, -1, 31, 16, -1, -1, 16};
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_valid        = 1'b0;
        mode            = i2cbs_pkg::MODE_LOAD;
        buffer_index    = '0;
        buffer_byte     = '0;
        bus_event       = '0;
        received_byte   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass; fill the whole buffer first so no entry is read unwritten
        program_length(3, 1'b0);
        for (int i = 0; i < BUF_DEPTH; i++)
            send_load(4'(i), (i == 0) ? 8'hA0 : (i == 1) ? 8'h00 :
                             (i == BUF_DEPTH - 1) ? 8'hFF : 8'($urandom));
        send_event(i2cbs_pkg::EV_DATAW_ACK);         // idle, ignored
        send_item(i2cbs_pkg::MODE_READ, 4'd15, 8'($urandom), 4'($urandom));
        send_item(i2cbs_pkg::MODE_START, 4'd0, 8'($urandom), 4'($urandom));
        // busy, rejected
        send_item(i2cbs_pkg::MODE_START, 4'd0, 8'($urandom), 4'($urandom));
        send_load(4'd1, 8'h5A);                      // busy, dropped
        send_event(i2cbs_pkg::EV_START);
        send_event(i2cbs_pkg::EV_ARB_LOST);
        send_event(i2cbs_pkg::EV_RESTART);
        send_event(i2cbs_pkg::EV_ADDRW_ACK);
        send_event(i2cbs_pkg::EV_DATAW_ACK);
        send_event(i2cbs_pkg::EV_DATAW_ACK);         // past length: stop
        send_item(i2cbs_pkg::MODE_START, 4'd0, 8'($urandom), 4'($urandom));
        send_event(i2cbs_pkg::EV_START);
        send_event(EV_OTHER_LAST);
        send_item(i2cbs_pkg::MODE_START, 4'd0, 8'($urandom), 4'($urandom));
        send_event(EV_ADDRW_NACK);
        send_item(i2cbs_pkg::MODE_START, 4'd0, 8'($urandom), 4'($urandom));
        send_event(EV_BUS_ERROR);

        for (int p = 0; p < 12; p++)
        begin
            program_length((phase_len[p] < 0) ? $urandom_range(16) : phase_len[p], p == 6);
            case (p % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1:
                begin
                    sender_idle_pct = 73;
                    recv_stall_pct  = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 73;
                end
                default:
                begin
                    sender_idle_pct = 37;
                    recv_stall_pct  = 37;
                end
            endcase
            goal = counted_items + 42;
            while (counted_items < goal)
                run_transfer();
        end

        in_valid <= 1'b0;
        guard = 0;
        while (sb.expected_results.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        if (sb.expected_results.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_results.size()));
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("i2c_master_byte_sequencer_tb OK");
        else
            $display("i2c_master_byte_sequencer_tb NOT OK");
        $finish;
    end

endmodule
